/* hw/rtl/gaborish_3x3_row_filter_top_macros.svh */
// Assertion macros shared by the filter's RTL files.
`ifndef GABORISH_3X3_ROW_FILTER_TOP_MACROS_SVH
`define GABORISH_3X3_ROW_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gb3 assertion failed");
// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gb3 assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/gb3_pkg.sv */
// Shared types, widths and constants of the 3x3 row filter.
package gb3_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int SUM_W        = SAMPLE_BITS + 2;   // sum of four samples
	localparam int WEIGHT_W     = 16;
	localparam int NORM_W       = 17;
	localparam int PSUM_W       = SUM_W + WEIGHT_W + 1;
	localparam int ACC_W        = SAMPLE_BITS + 20;
	localparam int MAG_W        = ACC_W - 1;
	localparam int PROD_W       = MAG_W + NORM_W;
	localparam int FRAC_SHIFT   = 32;
	localparam int Q_W          = PROD_W + 1 - FRAC_SHIFT;
	localparam int CENTRE_SHIFT = 16;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = NORM_W;

	localparam logic [WEIGHT_W-1:0] SIDE_WEIGHT_RST = WEIGHT_W'(7548);
	localparam logic [WEIGHT_W-1:0] DIAG_WEIGHT_RST = WEIGHT_W'(4014);
	localparam logic [NORM_W-1:0]   NORM_RST        = NORM_W'(38422);

	localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_SHIFT - 1);
	localparam logic [Q_W-1:0]  NEG_LIMIT  = Q_W'(1) << (SAMPLE_BITS - 1);
	localparam logic [Q_W-1:0]  POS_LIMIT  = NEG_LIMIT - Q_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SIDE_WEIGHT     = 2'd0,
		CFG_DIAGONAL_WEIGHT = 2'd1,
		CFG_NORMALISATION   = 2'd2
	} cfg_reg_e;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]       sum_t;

	typedef struct packed {
		sample_t top_sample;
		sample_t centre_sample;
		sample_t bottom_sample;
		logic    last_in_row;
	} pixel_t;

	typedef struct packed {
		sample_t filtered_sample;
		logic    last_of_row;
	} result_t;

	typedef struct packed {
		sample_t t;
		sample_t c;
		sample_t b;
	} column_t;

	// one filter job: centre plus the two neighbour sums
	typedef struct packed {
		sample_t centre;
		sum_t    side_sum;
		sum_t    diag_sum;
		logic    last;
	} job_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] side_weight;
		logic [WEIGHT_W-1:0] diagonal_weight;
		logic [NORM_W-1:0]   normalisation;
	} cfg_t;

endpackage

/* hw/rtl/gb3_front.sv */
// Front end: column window, edge replication and job generation.
`include "gaborish_3x3_row_filter_top_macros.svh"
module gb3_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pixel_valid,
	output logic            pixel_stall,
	input  gb3_pkg::pixel_t pixel,
	input  logic            q_full,
	output logic            push,
	output gb3_pkg::job_t   push_job
);
	import gb3_pkg::*;

	function automatic job_t make_job(column_t l, column_t m, column_t r, logic last);
		job_t j;
		j.centre   = m.c;
		j.side_sum = SUM_W'(m.t) + SUM_W'(m.b) + SUM_W'(l.c) + SUM_W'(r.c);
		j.diag_sum = SUM_W'(l.t) + SUM_W'(r.t) + SUM_W'(l.b) + SUM_W'(r.b);
		j.last     = last;
		return j;
	endfunction

	column_t w0_q, w1_q, cur;
	logic    held_q;     // a column of this row is in the window
	logic    pending_q;  // row-end flush job still to issue
	logic    accept;

	assign cur         = '{t: pixel.top_sample, c: pixel.centre_sample, b: pixel.bottom_sample};
	assign pixel_stall = pending_q || q_full;
	assign accept      = pixel_valid && !pixel_stall;

	always_comb begin
		push     = 1'b0;
		push_job = make_job(w0_q, w1_q, cur, 1'b0);
		if (pending_q) begin
			// right edge: the last column stands in for its missing neighbour
			push     = !q_full;
			push_job = make_job(w0_q, w1_q, w1_q, 1'b1);
		end else if (accept) begin
			if (held_q) begin
				push = 1'b1;
			end else if (pixel.last_in_row) begin
				push     = 1'b1;
				push_job = make_job(cur, cur, cur, 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q      <= '0;
			w1_q      <= '0;
			held_q    <= 1'b0;
			pending_q <= 1'b0;
		end else begin
			if (pending_q && !q_full) begin
				pending_q <= 1'b0;
			end
			if (accept) begin
				if (!held_q) begin
					// left edge: first column fills both slots
					w0_q   <= cur;
					w1_q   <= cur;
					held_q <= !pixel.last_in_row;
				end else begin
					w0_q <= w1_q;
					w1_q <= cur;
					if (pixel.last_in_row) begin
						held_q    <= 1'b0;
						pending_q <= 1'b1;
					end
				end
			end
		end
	end

	`ASSERT_NXT(a_row_end_flush, accept && held_q && pixel.last_in_row, pending_q && !held_q)
	`ASSERT_IMP(a_push_has_room, push, !q_full)

endmodule

/* hw/rtl/gb3_queue.sv */
// Small job queue between the front end and the arithmetic pipeline.
`include "gaborish_3x3_row_filter_top_macros.svh"
module gb3_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gb3_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output gb3_pkg::job_t head_job
);
	import gb3_pkg::*;

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

	`ASSERT_IMP(a_pop_not_empty, pop, head_valid)
	`ASSERT_IMP(a_count_bound, 1'b1, count_q <= (QPTR_W + 1)'(QUEUE_DEPTH))

endmodule

/* hw/rtl/gb3_back.sv */
// Back end: weighted sum, normalization, rounding and saturation pipeline.
`include "gaborish_3x3_row_filter_top_macros.svh"
module gb3_back (
	input  logic             clk,
	input  logic             arst_n,
	input  gb3_pkg::cfg_t    cfg,
	input  logic             head_valid,
	input  gb3_pkg::job_t    head_job,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output gb3_pkg::result_t result
);
	import gb3_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, res_valid_q;

	sample_t                  centre_s1;
	logic signed [PSUM_W-1:0] side_p_s1, diag_p_s1;
	logic                     last_s1;
	logic signed [ACC_W-1:0]  acc_s2;
	logic                     last_s2;
	logic [MAG_W-1:0]         mag_s3;
	logic                     neg_s3, last_s3;
	logic [PROD_W-1:0]        prod_s4;
	logic                     neg_s4, last_s4;
	result_t                  res_q;

	logic signed [ACC_W-1:0]  abs_acc;
	logic [PROD_W:0]          rounded;
	logic [Q_W-1:0]           q_mag, q_sat;
	logic [Q_W-1:0]           q_neg;
	sample_t                  y;

	// whole pipeline moves together; it freezes only while the output is held
	assign adv          = !res_valid_q || !result_stall;
	assign pop          = head_valid && adv;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign abs_acc = acc_s2[ACC_W-1] ? -acc_s2 : acc_s2;

	always_comb begin
		rounded = {1'b0, prod_s4} + ROUND_HALF;
		q_mag   = rounded[PROD_W:FRAC_SHIFT];
		if (neg_s4) begin
			q_sat = (q_mag > NEG_LIMIT) ? NEG_LIMIT : q_mag;
			q_neg = Q_W'(0) - q_sat;
			y     = q_neg[SAMPLE_BITS-1:0];
		end else begin
			q_sat = (q_mag > POS_LIMIT) ? POS_LIMIT : q_mag;
			q_neg = q_sat;
			y     = q_neg[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			centre_s1 <= head_job.centre;
			side_p_s1 <= PSUM_W'(head_job.side_sum) * $signed({1'b0, cfg.side_weight});
			diag_p_s1 <= PSUM_W'(head_job.diag_sum) * $signed({1'b0, cfg.diagonal_weight});
			last_s1   <= head_job.last;

			acc_s2  <= (ACC_W'(centre_s1) <<< CENTRE_SHIFT) + ACC_W'(side_p_s1)
				+ ACC_W'(diag_p_s1);
			last_s2 <= last_s1;

			neg_s3  <= acc_s2[ACC_W-1];
			mag_s3  <= abs_acc[MAG_W-1:0];
			last_s3 <= last_s2;

			prod_s4 <= PROD_W'(mag_s3) * PROD_W'(cfg.normalisation);
			neg_s4  <= neg_s3;
			last_s4 <= last_s3;

			res_q.filtered_sample <= y;
			res_q.last_of_row     <= last_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= head_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			res_valid_q <= v_s4;
		end
	end

	`ASSERT_NXT(a_pop_enters_pipe, pop, v_s1)
	`ASSERT_NXT(a_stage_reaches_out, adv && v_s4, result_valid)

endmodule

/* hw/rtl/gaborish_3x3_row_filter_top.sv */
// Top level of the 3x3 Gaborish row filter: config registers and block wiring.
//
// Usage: one pixel column (top, centre, bottom sample, Q3.12) transfers on the
// pixel channel when pixel_valid is high and pixel_stall is low. Filtered
// centre-row samples leave on the result channel under the same rule with
// result_stall driven by the receiver. Output lags input by one column; the
// column flagged last_in_row releases two results, the second with
// last_of_row set (a one-column row releases just one).
// Throughput: one column per cycle while the queue has room; after a row-end
// column the pixel channel stalls while the front end issues the right-edge job.
// Path: the result of the column that completes its window passes the queue
// slot, two multiply/sum stages, magnitude, normalization multiply and the
// round/saturate output register; the row-end flush job is issued after the
// last column's transfer, once the queue has room, and takes the same path.
// Stall: the result register holds and the whole back pipeline freezes; the
// four-job queue keeps accepting until full, then pixel_stall rises.
// Reset: weights and normalization take their defaults, the window is cleared
// and the next column starts a row; queue and pipeline are empty.
// Config: cfg_ready is always high; write only while the block is idle.
module gaborish_3x3_row_filter_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pixel_valid,
	output logic                             pixel_stall,
	input  gb3_pkg::pixel_t                  pixel,
	output logic                             result_valid,
	input  logic                             result_stall,
	output gb3_pkg::result_t                 result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gb3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gb3_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import gb3_pkg::*;

	cfg_t cfg_q;

	// front -> queue
	logic push, q_full;
	job_t push_job;

	// queue -> back
	logic head_valid, pop;
	job_t head_job;

	// register writes complete in the cycle they are offered
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.side_weight     <= SIDE_WEIGHT_RST;
			cfg_q.diagonal_weight <= DIAG_WEIGHT_RST;
			cfg_q.normalisation   <= NORM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SIDE_WEIGHT:     cfg_q.side_weight     <= cfg_data[WEIGHT_W-1:0];
				CFG_DIAGONAL_WEIGHT: cfg_q.diagonal_weight <= cfg_data[WEIGHT_W-1:0];
				CFG_NORMALISATION:   cfg_q.normalisation   <= cfg_data[NORM_W-1:0];
				default: ;  // unmapped index: write dropped
			endcase
		end
	end

	// window, edge replication, job issue
	gb3_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.q_full      (q_full),
		.push        (push),
		.push_job    (push_job)
	);

	// decouples column intake from result back-pressure
	gb3_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// weighted sum, normalize, round, saturate
	gb3_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the streaming 3x3 Gaborish row filter.
`timescale 1ns / 100ps

module tb_top;
	import gb3_pkg::*;

	// cfg_index 3 is outside the register map; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

	localparam sample_t SAMPLE_MAX = 16'sh7FFF;
	localparam sample_t SAMPLE_MIN = 16'sh8000;

	localparam int SETTLE_CYCLES   = 12;      // settle time after the last expected result is out
	localparam int CYCLE_LIMIT     = 400000;  // far beyond the slowest legal run
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 175;
	localparam int STEADY_PHASE    = 5;       // no idling on either side here
	localparam int MAX_PRINTED     = 50;

	// Expected-result store plus its own copy of the filter state.
	class row_filter_checker;
		longint  side_w;
		longint  diag_w;
		longint  norm_q16;
		column_t win [2];
		int      held;
		result_t pending_results [$];
		int      errors;

		function new();
			side_w   = longint'(SIDE_WEIGHT_RST);
			diag_w   = longint'(DIAG_WEIGHT_RST);
			norm_q16 = longint'(NORM_RST);
			win[0]   = '0;
			win[1]   = '0;
			held     = 0;
			errors   = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_SIDE_WEIGHT:     side_w   = longint'(data[WEIGHT_W-1:0]);
				CFG_DIAGONAL_WEIGHT: diag_w   = longint'(data[WEIGHT_W-1:0]);
				CFG_NORMALISATION:   norm_q16 = longint'(data[NORM_W-1:0]);
				default: ;
			endcase
		endfunction

		// exact Q.28 accumulate, one normalize multiply, round half away, saturate
		function sample_t filter_window(column_t l, column_t m, column_t r);
			longint      side;
			longint      diag;
			longint      acc;
			longint      max_pos;
			longint      y;
			logic        neg;
			logic [63:0] mag;
			logic [63:0] q;
			side    = longint'(m.t) + longint'(m.b) + longint'(l.c) + longint'(r.c);
			diag    = longint'(l.t) + longint'(r.t) + longint'(l.b) + longint'(r.b);
			acc     = (longint'(m.c) <<< CENTRE_SHIFT) + side * side_w + diag * diag_w;
			neg     = acc < 0;
			mag     = neg ? 64'(-acc) : 64'(acc);
			q       = (mag * 64'(norm_q16) + (64'd1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
			max_pos = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
			if (neg) begin
				if (q > 64'(max_pos + 1))
					q = 64'(max_pos + 1);
				y = -longint'(q);
			end else begin
				if (q > 64'(max_pos))
					q = 64'(max_pos);
				y = longint'(q);
			end
			return sample_t'(y);
		endfunction

		// one accepted column: emits the lagged output, and the flush at row end
		function void take_column(pixel_t px);
			column_t cur;
			cur.t = px.top_sample;
			cur.c = px.centre_sample;
			cur.b = px.bottom_sample;
			if (held == 0) begin
				win[0] = cur;
				win[1] = cur;
				held   = 1;
			end else begin
				pending_results.push_back('{filtered_sample: filter_window(win[0], win[1], cur),
					last_of_row: 1'b0});
				win[0] = win[1];
				win[1] = cur;
				held   = 2;
			end
			if (px.last_in_row) begin
				pending_results.push_back('{filtered_sample: filter_window(win[0], win[1], cur),
					last_of_row: 1'b1});
				held = 0;
			end
		endfunction

		task report(string msg);
			if (errors < MAX_PRINTED)
				$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result %0d last=%0b",
					got.filtered_sample, got.last_of_row));
			end else begin
				want = pending_results.pop_front();
				if (got.filtered_sample !== want.filtered_sample)
					report($sformatf("filtered_sample got %0d want %0d",
						got.filtered_sample, want.filtered_sample));
				if (got.last_of_row !== want.last_of_row)
					report($sformatf("last_of_row got %0b want %0b",
						got.last_of_row, want.last_of_row));
			end
		endtask
	endclass

	// Block inputs start at known values; all later changes are NBAs at posedge.
	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   pixel_valid  = 1'b0;
	logic                   pixel_stall;
	pixel_t                 pixel        = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	result_t                result;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;

	row_filter_checker chk;
	bit                steady     = 1'b0;   // suppresses random idling on both sides
	int                stall_left = 0;
	int                cycles     = 0;

	gaborish_3x3_row_filter_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Monitors sample at the edge, before any NBA of that step lands, so every
	// transfer is seen exactly as the block saw it.
	always @(posedge clk) begin
		if (arst_n && pixel_valid && !pixel_stall)
			chk.take_column(pixel);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			chk.check_result(result);
	end

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			chk.set_register(cfg_index, cfg_data);
	end

	// Receiver back-pressure: ~14% single-cycle stalls, now and then a short burst
	// so the internal job queue fills and pixel_stall gets exercised.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left   <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (!steady && $urandom_range(0, 99) < 14) begin
			result_stall <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				stall_left <= $urandom_range(1, 7);
		end else begin
			result_stall <= 1'b0;
		end
	end

	function automatic pixel_t make_column(sample_t t, sample_t c, sample_t b, logic last);
		return '{top_sample: t, centre_sample: c, bottom_sample: b, last_in_row: last};
	endfunction

	// Mix of rails, small values and full-range noise.
	function automatic sample_t rand_sample();
		case ($urandom_range(0, 7))
			0:       return SAMPLE_MAX;
			1:       return SAMPLE_MIN;
			2:       return sample_t'(int'($urandom_range(0, 511)) - 256);
			default: return sample_t'($urandom());
		endcase
	endfunction

	function automatic int row_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return 1;
		else if (pick < 75)
			return $urandom_range(2, 8);
		else
			return $urandom_range(9, 40);
	endfunction

	// Normalization that software would program: 2^32 / (2^16 + 4*(sw + dw)).
	function automatic logic [NORM_W-1:0] matched_norm(logic [WEIGHT_W-1:0] sw,
		logic [WEIGHT_W-1:0] dw);
		return NORM_W'((longint'(1) <<< 32) /
			(longint'(65536) + 4 * (longint'(sw) + longint'(dw))));
	endfunction

	// One column transfer. Valid stays high between back-to-back columns.
	task send_column(pixel_t px);
		while (!steady && $urandom_range(0, 99) < 14) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel       <= px;
		pixel_valid <= 1'b1;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
	endtask

	task send_row(int len);
		for (int i = 0; i < len; i++)
			send_column(make_column(rand_sample(), rand_sample(), rand_sample(), i == len - 1));
	endtask

	// Hold off the sender until every expected result is out, then let the
	// pipeline settle. The first edge lets the input monitor log the last transfer.
	task drain();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (chk.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task wait_cfg();
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Full register set plus a stray write to the unused index. Bit 16 of the
	// weight writes is random: the block must mask it off.
	task program_regs(logic [WEIGHT_W-1:0] sw, logic [WEIGHT_W-1:0] dw,
		logic [NORM_W-1:0] nrm);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_SIDE_WEIGHT;
		cfg_data  <= {1'($urandom()), sw};
		wait_cfg();
		cfg_index <= CFG_DIAGONAL_WEIGHT;
		cfg_data  <= {1'($urandom()), dw};
		wait_cfg();
		cfg_index <= CFG_NORMALISATION;
		cfg_data  <= nrm;
		wait_cfg();
		cfg_index <= CFG_SPARE_INDEX;
		cfg_data  <= CFG_DATA_W'($urandom());
		wait_cfg();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int                  sent;
		int                  len;
		logic [WEIGHT_W-1:0] sw;
		logic [WEIGHT_W-1:0] dw;
		logic [NORM_W-1:0]   nrm;

		chk = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset-default registers ---
		// one-column rows at both rails: single result, window is the column itself
		send_column(make_column(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1));
		send_column(make_column(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b1));
		// two-column row: left and right edges both replicate
		send_column(make_column(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b0));
		send_column(make_column(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b1));
		// longer row with bit patterns and zero
		send_column(make_column(16'sh0000, 16'sh0000, 16'sh0000, 1'b0));
		send_column(make_column(16'sh0001, 16'shFFFF, 16'sh0001, 1'b0));
		send_column(make_column(16'sh5555, 16'shAAAA, 16'sh5555, 1'b0));
		send_column(make_column(16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0));
		send_column(make_column(rand_sample(), rand_sample(), rand_sample(), 1'b1));
		drain();

		// max weights with normalization above 1.0: heavy saturation
		program_regs(16'hFFFF, 16'hFFFF, 17'h1FFFF);
		send_column(make_column(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0));
		send_column(make_column(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0));
		send_column(make_column(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b1));
		send_column(make_column(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b1));
		drain();

		// zero weights, unity normalization: pass-through of the centre row
		program_regs(16'h0000, 16'h0000, 17'h10000);
		send_column(make_column(SAMPLE_MAX, 16'sh1234, SAMPLE_MIN, 1'b0));
		send_column(make_column(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, 1'b0));
		send_column(make_column(16'sh0000, SAMPLE_MAX, 16'sh0000, 1'b0));
		send_column(make_column(16'sh7000, 16'shFFFF, 16'sh9000, 1'b1));
		drain();

		// zero normalization: every output is zero
		program_regs(16'd1000, 16'd500, 17'h00000);
		send_column(make_column(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b0));
		send_column(make_column(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b1));
		drain();

		// --- random phases, each under its own register setting ---
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph % 4)
				0: begin
					sw  = WEIGHT_W'($urandom());
					dw  = WEIGHT_W'($urandom());
					nrm = matched_norm(sw, dw);
				end
				1: begin
					sw  = WEIGHT_W'($urandom());
					dw  = WEIGHT_W'($urandom());
					nrm = NORM_W'($urandom());
				end
				2: begin
					sw  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					dw  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					case ($urandom_range(0, 2))
						0:       nrm = 17'h00000;
						1:       nrm = 17'h10000;
						default: nrm = 17'h1FFFF;
					endcase
				end
				default: begin
					sw  = WEIGHT_W'($urandom_range(0, 12000));
					dw  = WEIGHT_W'($urandom_range(0, 8000));
					nrm = matched_norm(sw, dw);
				end
			endcase
			program_regs(sw, dw, nrm);
			steady = (ph == STEADY_PHASE);

			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				len = row_length();
				send_row(len);
				sent += len;
				// occasional mid-phase hold-off until the block runs dry
				if ($urandom_range(0, 29) == 0)
					drain();
			end
			drain();
			steady = 1'b0;
		end

		drain();
		if (chk.pending_results.size() != 0)
			chk.report($sformatf("%0d results never arrived", chk.pending_results.size()));

		if (chk.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
